/* rtl/m4m_pkg.sv */
// shared constants and types for the 4x4 fixed-point matrix multiplier
package m4m_pkg;

    // matrix shape and number format
    localparam int DIM       = 4;
    localparam int FRAC_BITS = 16;

    // derived sizes
    localparam int CELLS     = DIM * DIM;
    localparam int LOADS     = 2 * CELLS;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W + $clog2(DIM);
    localparam int IDX_W     = $clog2(DIM);
    localparam int CELL_W    = $clog2(CELLS);
    localparam int LOAD_W    = $clog2(LOADS);
    localparam int POS_W     = 2;

    // saturation limits of the result
    localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // bookkeeping that travels with each multiply-accumulate step
    typedef struct packed {
        logic             first;
        logic             last;
        logic             tail;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

endpackage

/* rtl/m4m_mac.sv */
// shared multiply-accumulate unit with shift and saturate on the finished sum
module m4m_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  m4m_pkg::t_tag                       i_tag,
    input  logic signed [m4m_pkg::ELEM_W-1:0]   i_a,
    input  logic signed [m4m_pkg::ELEM_W-1:0]   i_b,
    output logic                                o_valid,
    output logic        [m4m_pkg::ELEM_W-1:0]   o_value,
    output logic        [m4m_pkg::IDX_W-1:0]    o_row,
    output logic        [m4m_pkg::IDX_W-1:0]    o_col,
    output logic                                o_last
);

    logic signed [m4m_pkg::PROD_W-1:0] r_prod;
    logic                              r_prod_v;
    m4m_pkg::t_tag                     r_prod_tag;

    logic signed [m4m_pkg::ACC_W-1:0]  r_acc;
    logic                              r_acc_done;
    m4m_pkg::t_tag                     r_acc_tag;

    logic signed [m4m_pkg::ACC_W-1:0]  w_shift;
    logic [m4m_pkg::ACC_W-m4m_pkg::ELEM_W:0] w_upper;
    logic                              w_fits;

    logic                              r_out_v;
    logic                              r_out_last;
    logic [m4m_pkg::ELEM_W-1:0]        r_out_value;
    logic [m4m_pkg::IDX_W-1:0]         r_out_row;
    logic [m4m_pkg::IDX_W-1:0]         r_out_col;

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_prod     <= i_a * i_b;
        r_prod_tag <= i_tag;
        if (!i_rst_n) begin
            r_prod_v <= 1'b0;
        end else begin
            r_prod_v <= i_valid;
        end
    end

    // accumulate stage, restarting on the first term of each entry
    always_ff @(posedge i_clk) begin
        if (r_prod_v) begin
            if (r_prod_tag.first) begin
                r_acc <= m4m_pkg::ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + m4m_pkg::ACC_W'(r_prod);
            end
        end
        r_acc_tag <= r_prod_tag;
        if (!i_rst_n) begin
            r_acc_done <= 1'b0;
        end else begin
            r_acc_done <= r_prod_v & r_prod_tag.last;
        end
    end

    // drop fraction bits (floor) and check the range of what remains
    assign w_shift = r_acc >>> m4m_pkg::FRAC_BITS;
    assign w_upper = w_shift[m4m_pkg::ACC_W-1:m4m_pkg::ELEM_W-1];
    assign w_fits  = (&w_upper) | ~(|w_upper);

    // output register
    always_ff @(posedge i_clk) begin
        if (w_fits) begin
            r_out_value <= w_shift[m4m_pkg::ELEM_W-1:0];
        end else if (w_shift[m4m_pkg::ACC_W-1]) begin
            r_out_value <= m4m_pkg::SAT_MIN;
        end else begin
            r_out_value <= m4m_pkg::SAT_MAX;
        end
        r_out_row <= r_acc_tag.row;
        r_out_col <= r_acc_tag.col;
        if (!i_rst_n) begin
            r_out_v    <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_out_v    <= r_acc_done;
            r_out_last <= r_acc_done & r_acc_tag.tail;
        end
    end

    assign o_valid = r_out_v;
    assign o_value = r_out_value;
    assign o_row   = r_out_row;
    assign o_col   = r_out_col;
    assign o_last  = r_out_last;

    // a finished sum always comes from a last term in the cycle before
    a_done_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_done |-> $past(r_prod_v && r_prod_tag.last))
        else $error("accumulator finished without a last term");

    // a saturated value only appears when the sum is out of range
    a_sat_only_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_done && w_fits) |=> (r_out_value == $past(w_shift[m4m_pkg::ELEM_W-1:0])))
        else $error("in-range sum was altered");

    // the final marker only rides on a valid result
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_last |-> r_out_v)
        else $error("last marker without result");

endmodule

/* rtl/matrix4x4_multiply.sv */
// top level: element loader, operand stores, step sequencer and the shared mac
// loading takes one element per cycle; busy stays low while the 32 elements come in
// after the edge that takes the last element, busy stays high until all mac steps are issued
// results leave the mac's output register, one per entry, after its last inner-index term
// no element is taken while busy is high; the single 32x32 multiplier serves every mac step
// results cannot be stalled; synchronous active-low reset clears counters and strobes
module matrix4x4_multiply (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [m4m_pkg::ELEM_W-1:0]  i_elem_value,
    output logic                               o_prod_valid,
    output logic signed [m4m_pkg::ELEM_W-1:0]  o_prod_value,
    output logic        [m4m_pkg::POS_W-1:0]   o_prod_row,
    output logic        [m4m_pkg::POS_W-1:0]   o_prod_col,
    output logic                               o_last_elem
);

    logic [m4m_pkg::ELEM_W-1:0] r_left_mem  [m4m_pkg::CELLS];
    logic [m4m_pkg::ELEM_W-1:0] r_right_mem [m4m_pkg::CELLS];

    logic [m4m_pkg::LOAD_W-1:0] r_load_cnt;
    logic [m4m_pkg::LOAD_W-1:0] n_load_cnt;
    logic                       w_accept;
    logic                       w_load_done;
    logic                       w_to_left;
    logic [m4m_pkg::CELL_W-1:0] w_wr_left;
    logic [m4m_pkg::CELL_W-1:0] w_wr_right;

    logic                       r_run;
    logic                       n_run;
    logic [m4m_pkg::IDX_W-1:0]  r_i;
    logic [m4m_pkg::IDX_W-1:0]  r_j;
    logic [m4m_pkg::IDX_W-1:0]  r_k;
    logic [m4m_pkg::IDX_W-1:0]  n_i;
    logic [m4m_pkg::IDX_W-1:0]  n_j;
    logic [m4m_pkg::IDX_W-1:0]  n_k;
    logic                       w_k_end;
    logic                       w_j_end;
    logic                       w_i_end;
    logic [m4m_pkg::CELL_W-1:0] w_rd_left;
    logic [m4m_pkg::CELL_W-1:0] w_rd_right;

    logic signed [m4m_pkg::ELEM_W-1:0] r_left_rd;
    logic signed [m4m_pkg::ELEM_W-1:0] r_right_rd;
    logic                              r_rd_v;
    m4m_pkg::t_tag                     r_rd_tag;
    m4m_pkg::t_tag                     w_tag;

    logic [m4m_pkg::ELEM_W-1:0] w_mac_value;
    logic [m4m_pkg::IDX_W-1:0]  w_mac_row;
    logic [m4m_pkg::IDX_W-1:0]  w_mac_col;

    // request handshake and load addressing
    assign w_accept    = start & ~busy;
    assign w_load_done = (r_load_cnt == m4m_pkg::LOAD_W'(m4m_pkg::LOADS - 1));
    assign w_to_left   = (r_load_cnt < m4m_pkg::LOAD_W'(m4m_pkg::CELLS));
    assign w_wr_left   = m4m_pkg::CELL_W'(r_load_cnt);
    assign w_wr_right  = m4m_pkg::CELL_W'(r_load_cnt - m4m_pkg::LOAD_W'(m4m_pkg::CELLS));

    // load counter wraps after the right matrix is complete
    always_comb begin
        n_load_cnt = r_load_cnt;
        if (w_accept) begin
            if (w_load_done) begin
                n_load_cnt = '0;
            end else begin
                n_load_cnt = r_load_cnt + 1'b1;
            end
        end
    end

    // operand stores
    always_ff @(posedge i_clk) begin
        if (w_accept && w_to_left) begin
            r_left_mem[w_wr_left] <= i_elem_value;
        end
        if (w_accept && !w_to_left) begin
            r_right_mem[w_wr_right] <= i_elem_value;
        end
    end

    // step sequencer over row, column and inner index
    assign w_k_end = (r_k == m4m_pkg::IDX_W'(m4m_pkg::DIM - 1));
    assign w_j_end = (r_j == m4m_pkg::IDX_W'(m4m_pkg::DIM - 1));
    assign w_i_end = (r_i == m4m_pkg::IDX_W'(m4m_pkg::DIM - 1));

    always_comb begin
        n_run = r_run;
        n_i   = r_i;
        n_j   = r_j;
        n_k   = r_k;
        if (r_run) begin
            if (!w_k_end) begin
                n_k = r_k + 1'b1;
            end else begin
                n_k = '0;
                if (!w_j_end) begin
                    n_j = r_j + 1'b1;
                end else begin
                    n_j = '0;
                    if (!w_i_end) begin
                        n_i = r_i + 1'b1;
                    end else begin
                        n_i   = '0;
                        n_run = 1'b0;
                    end
                end
            end
        end else if (w_accept && w_load_done) begin
            n_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            r_run      <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
        end else begin
            r_load_cnt <= n_load_cnt;
            r_run      <= n_run;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
        end
    end

    assign busy = r_run;

    // operand read addresses: left[i][k] and right[k][j]
    assign w_rd_left  = m4m_pkg::CELL_W'(r_i * m4m_pkg::DIM + r_k);
    assign w_rd_right = m4m_pkg::CELL_W'(r_k * m4m_pkg::DIM + r_j);

    always_comb begin
        w_tag.first = (r_k == '0);
        w_tag.last  = w_k_end;
        w_tag.tail  = w_i_end & w_j_end;
        w_tag.row   = r_i;
        w_tag.col   = r_j;
    end

    // registered store reads
    always_ff @(posedge i_clk) begin
        r_left_rd  <= r_left_mem[w_rd_left];
        r_right_rd <= r_right_mem[w_rd_right];
        r_rd_tag   <= w_tag;
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= r_run;
        end
    end

    // shared multiply-accumulate unit
    m4m_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_v),
        .i_tag   (r_rd_tag),
        .i_a     (r_left_rd),
        .i_b     (r_right_rd),
        .o_valid (o_prod_valid),
        .o_value (w_mac_value),
        .o_row   (w_mac_row),
        .o_col   (w_mac_col),
        .o_last  (o_last_elem)
    );

    assign o_prod_value = w_mac_value;
    assign o_prod_row   = m4m_pkg::POS_W'(w_mac_row);
    assign o_prod_col   = m4m_pkg::POS_W'(w_mac_col);

    // the load counter sits at zero while products are being formed
    a_cnt_idle_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_load_cnt == '0))
        else $error("load counter moved during compute");

    // the sequencer rests at the origin when not running
    a_seq_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> (r_i == '0 && r_j == '0 && r_k == '0))
        else $error("sequencer indices not parked");

    // compute starts only right after the last element of the right matrix
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_run) |-> $past(w_accept && w_load_done))
        else $error("compute started without a full load");

    // the final product carries the last row and column
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_elem |-> (w_mac_row == m4m_pkg::IDX_W'(m4m_pkg::DIM - 1)
                         && w_mac_col == m4m_pkg::IDX_W'(m4m_pkg::DIM - 1)))
        else $error("last marker on wrong product entry");

endmodule

/* bench/m4m_checker.sv */
// checker for the matrix multiplier: predicts product elements and compares results
module m4m_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic signed [m4m_pkg::ELEM_W-1:0]  i_elem_value,
    input  logic                               o_prod_valid,
    input  logic signed [m4m_pkg::ELEM_W-1:0]  o_prod_value,
    input  logic        [m4m_pkg::POS_W-1:0]   o_prod_row,
    input  logic        [m4m_pkg::POS_W-1:0]   o_prod_col,
    input  logic                               o_last_elem,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W = 68;

    // one expected product element
    typedef struct {
        logic [m4m_pkg::ELEM_W-1:0] value;
        logic [m4m_pkg::POS_W-1:0]  row;
        logic [m4m_pkg::POS_W-1:0]  col;
        logic                       last;
    } t_prod_elem;

    t_prod_elem        product_q[$];
    logic signed [m4m_pkg::ELEM_W-1:0] left_mat  [m4m_pkg::CELLS];
    logic signed [m4m_pkg::ELEM_W-1:0] right_mat [m4m_pkg::CELLS];
    int                elem_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // prints one line per mismatch and counts it
    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("m4m_checker: mismatch at %0t: %s", $realtime, msg);
    endtask

    // exact dot product of a left row and a right column, floored and saturated
    function automatic logic [m4m_pkg::ELEM_W-1:0] dot_saturated(input int row, input int col);
        logic signed [SUM_W-1:0] acc;
        logic signed [SUM_W-1:0] lv;
        logic signed [SUM_W-1:0] rv;
        logic signed [SUM_W-1:0] scaled;
        acc = '0;
        for (int k = 0; k < m4m_pkg::DIM; k++) begin
            lv  = left_mat[row*m4m_pkg::DIM + k];
            rv  = right_mat[k*m4m_pkg::DIM + col];
            acc = acc + lv * rv;
        end
        scaled = acc >>> m4m_pkg::FRAC_BITS;
        if (scaled > 68'sh7fffffff)
            return m4m_pkg::SAT_MAX;
        if (scaled < ~68'sh7fffffff)
            return m4m_pkg::SAT_MIN;
        return scaled[m4m_pkg::ELEM_W-1:0];
    endfunction

    // compare results first, then take in the element accepted at this edge
    always @(posedge i_clk) begin
        t_prod_elem got;
        t_prod_elem exp_elem;
        if (i_rst_n) begin
            if (o_prod_valid) begin
                got.value = o_prod_value;
                got.row   = o_prod_row;
                got.col   = o_prod_col;
                got.last  = o_last_elem;
                if (product_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%h row=%0d col=%0d last=%0b",
                                              got.value, got.row, got.col, got.last));
                end else begin
                    exp_elem = product_q.pop_front();
                    if (got.value !== exp_elem.value || got.row !== exp_elem.row ||
                        got.col !== exp_elem.col || got.last !== exp_elem.last)
                        report_mismatch($sformatf(
                            "got value=%h row=%0d col=%0d last=%0b, want %h %0d %0d %0b",
                            got.value, got.row, got.col, got.last,
                            exp_elem.value, exp_elem.row, exp_elem.col, exp_elem.last));
                end
            end

            // element request accepted
            if (start && !busy) begin
                if (elem_count < m4m_pkg::CELLS)
                    left_mat[elem_count] = i_elem_value;
                else
                    right_mat[elem_count - m4m_pkg::CELLS] = i_elem_value;
                if (elem_count == m4m_pkg::LOADS - 1) begin
                    elem_count = 0;
                    for (int r = 0; r < m4m_pkg::DIM; r++) begin
                        for (int c = 0; c < m4m_pkg::DIM; c++) begin
                            exp_elem.value = dot_saturated(r, c);
                            exp_elem.row   = m4m_pkg::POS_W'(r);
                            exp_elem.col   = m4m_pkg::POS_W'(c);
                            exp_elem.last  = (r == m4m_pkg::DIM - 1) && (c == m4m_pkg::DIM - 1);
                            product_q.push_back(exp_elem);
                        end
                    end
                end else begin
                    elem_count++;
                end
            end
            o_pending = product_q.size();
        end
    end

endmodule

/* bench/tb_top.sv */
// testbench top: drives matrix element requests into the multiplier and gives the verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SETS    = 10;
    localparam int CYCLE_LIMIT = 60000;
    localparam int DRAIN_WAIT  = 20;

    logic                                i_clk        = 1'b0;
    logic                                i_rst_n      = 1'b0;
    logic                                start        = 1'b0;
    logic signed [m4m_pkg::ELEM_W-1:0]   i_elem_value = '0;
    logic                                busy;
    logic                                o_prod_valid;
    logic signed [m4m_pkg::ELEM_W-1:0]   o_prod_value;
    logic        [m4m_pkg::POS_W-1:0]    o_prod_row;
    logic        [m4m_pkg::POS_W-1:0]    o_prod_col;
    logic                                o_last_elem;
    int                                  fail_count;
    int                                  pending;
    int                                  cycle_count = 0;

    // directed pair: saturation both ways, floor rounding of small negatives
    logic [m4m_pkg::ELEM_W-1:0] directed_left [m4m_pkg::CELLS] = '{
        32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
        32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
        32'h00010000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'hffffffff, 32'h00000001, 32'h00008000, 32'hfffe0000
    };
    logic [m4m_pkg::ELEM_W-1:0] directed_right [m4m_pkg::CELLS] = '{
        32'h7fffffff, 32'h80000000, 32'h00010000, 32'hffffffff,
        32'h7fffffff, 32'h80000000, 32'h00000000, 32'h00000001,
        32'h7fffffff, 32'h80000000, 32'h00020000, 32'hffff0000,
        32'h7fffffff, 32'h80000000, 32'h00000000, 32'h00000001
    };

    matrix4x4_multiply dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_elem_value (i_elem_value),
        .o_prod_valid (o_prod_valid),
        .o_prod_value (o_prod_value),
        .o_prod_row   (o_prod_row),
        .o_prod_col   (o_prod_col),
        .o_last_elem  (o_last_elem)
    );

    m4m_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_elem_value (i_elem_value),
        .o_prod_valid (o_prod_valid),
        .o_prod_value (o_prod_value),
        .o_prod_row   (o_prod_row),
        .o_prod_col   (o_prod_col),
        .o_last_elem  (o_last_elem),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // one element request: optional idle gap with start low, then hold start until taken
    task automatic send_elem(input logic [m4m_pkg::ELEM_W-1:0] value, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_elem_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    // random element drawn from a mix of full-range, small, extreme and near-one values
    function automatic logic [m4m_pkg::ELEM_W-1:0] draw_elem();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 2)
            return $urandom();
        if (kind <= 6)
            return m4m_pkg::ELEM_W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        if (kind <= 8) begin
            unique case ($urandom_range(0, 4))
                0: return m4m_pkg::SAT_MAX;
                1: return m4m_pkg::SAT_MIN;
                2: return '0;
                3: return 32'h00000001;
                default: return 32'hffffffff;
            endcase
        end
        return m4m_pkg::ELEM_W'($signed($urandom_range(0, 32'h2000)) + 32'h0000f000);
    endfunction

    // stimulus and verdict
    initial begin
        bit no_gaps;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pair of matrices
        for (int n = 0; n < m4m_pkg::CELLS; n++)
            send_elem(directed_left[n], $urandom_range(0, 5));
        for (int n = 0; n < m4m_pkg::CELLS; n++)
            send_elem(directed_right[n], $urandom_range(0, 5));

        // random pairs, some sets with back-to-back requests
        for (int s = 0; s < NUM_SETS; s++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < m4m_pkg::LOADS; n++)
                send_elem(draw_elem(), no_gaps ? 0 : $urandom_range(0, 5));
        end
        start <= 1'b0;

        // let the checker take in the last request before looking at its backlog
        @(posedge i_clk);

        // drain outstanding products
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
